[rtl/smdi_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the small matrix determinant and inverse block
// no dependencies
package smdi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ELEM_W    = 32;
    localparam int N_ELEM    = 9;
    localparam int PROD_W    = 2 * ELEM_W;          // element product
    localparam int COF_W     = PROD_W + 1;          // 2x2 minor / cofactor
    localparam int PART_W    = COF_W;               // element times half cofactor
    localparam int DET_W     = COF_W + ELEM_W + 2;  // exact 3x3 determinant
    localparam int DMAG_W    = 96;                  // |det| < 3 * 2^94
    localparam int NUM_W     = PROD_W + 2 * FRAC_BITS;
    localparam int Q_BITS    = 34;                  // quotient bits kept before saturation
    localparam int REM_W     = DMAG_W + Q_BITS;
    localparam int DIV_LAT   = Q_BITS + 2;
    localparam int DETQ_W    = DMAG_W + 1;
    localparam logic [1:0] SIZE_3X3 = 2'd3;

    typedef struct packed {
        logic [1:0]               matrix_size;
        logic signed [ELEM_W-1:0] a_r0c0;
        logic signed [ELEM_W-1:0] a_r0c1;
        logic signed [ELEM_W-1:0] a_r0c2;
        logic signed [ELEM_W-1:0] a_r1c0;
        logic signed [ELEM_W-1:0] a_r1c1;
        logic signed [ELEM_W-1:0] a_r1c2;
        logic signed [ELEM_W-1:0] a_r2c0;
        logic signed [ELEM_W-1:0] a_r2c1;
        logic signed [ELEM_W-1:0] a_r2c2;
    } t_in_data;

    typedef struct packed {
        logic                     status;
        logic signed [63:0]       det_value;
        logic signed [ELEM_W-1:0] inv_r0c0;
        logic signed [ELEM_W-1:0] inv_r0c1;
        logic signed [ELEM_W-1:0] inv_r0c2;
        logic signed [ELEM_W-1:0] inv_r1c0;
        logic signed [ELEM_W-1:0] inv_r1c1;
        logic signed [ELEM_W-1:0] inv_r1c2;
        logic signed [ELEM_W-1:0] inv_r2c0;
        logic signed [ELEM_W-1:0] inv_r2c1;
        logic signed [ELEM_W-1:0] inv_r2c2;
    } t_out_data;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [DMAG_W-1:0] dvs;
        logic [Q_BITS-1:0] quo;
        logic              neg;
        logic              ovf;
    } t_div;

    typedef struct packed {
        logic              zero;
        logic [63:0]       det_q;
        logic [N_ELEM-1:0] used;
    } t_side;

endpackage

[rtl/smdi_in_if.sv]
`timescale 1ns / 1ps
// input channel: one matrix per transaction
// depends on smdi_pkg
interface smdi_in_if;
    logic                valid;
    logic                ready;
    smdi_pkg::t_in_data  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[rtl/smdi_out_if.sv]
`timescale 1ns / 1ps
// output channel: status, determinant and inverse per transaction
// depends on smdi_pkg
interface smdi_out_if;
    logic                valid;
    logic                ready;
    smdi_pkg::t_out_data data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[rtl/smdi_div_lane.sv]
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, round half away and saturate
// depends on smdi_pkg
module smdi_div_lane (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [smdi_pkg::NUM_W-1:0]         i_num,
    input  logic [smdi_pkg::DMAG_W-1:0]        i_den,
    input  logic                               i_neg,
    output logic [smdi_pkg::ELEM_W-1:0]        o_val
);

    localparam int QB = smdi_pkg::Q_BITS;
    localparam int RW = smdi_pkg::REM_W;

    smdi_pkg::t_div                 r_st [QB+1];
    logic [smdi_pkg::ELEM_W-1:0]    r_val;
    logic [QB:0]                    n_q1;
    logic                           n_rnd;
    logic [smdi_pkg::ELEM_W-1:0]    n_val;

    // quotient of 2^34 or more saturates in either sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].rem <= RW'(i_num);
            r_st[0].dvs <= i_den;
            r_st[0].quo <= '0;
            r_st[0].neg <= i_neg;
            r_st[0].ovf <= RW'(i_num) >= {i_den, {QB{1'b0}}};
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QB; k++) begin : g_bit
            localparam int B = QB - k;
            logic [RW-1:0] w_sub;
            logic          w_ge;
            assign w_sub = RW'(r_st[k-1].dvs) << B;
            assign w_ge  = r_st[k-1].rem >= w_sub;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k].rem <= w_ge ? r_st[k-1].rem - w_sub : r_st[k-1].rem;
                    r_st[k].quo <= r_st[k-1].quo | (w_ge ? (QB'(1) << B) : '0);
                    r_st[k].dvs <= r_st[k-1].dvs;
                    r_st[k].neg <= r_st[k-1].neg;
                    r_st[k].ovf <= r_st[k-1].ovf;
                end
            end
        end
    endgenerate

    always_comb begin
        n_rnd = {r_st[QB].rem, 1'b0} >= (RW+1)'(r_st[QB].dvs);
        n_q1  = (QB+1)'(r_st[QB].quo) + (QB+1)'(n_rnd);
        if (r_st[QB].neg) begin
            if (r_st[QB].ovf || n_q1 > (QB+1)'(64'h8000_0000)) begin
                n_val = 32'h8000_0000;
            end else begin
                n_val = 32'd0 - n_q1[31:0];
            end
        end else begin
            if (r_st[QB].ovf || n_q1 > (QB+1)'(64'h7FFF_FFFF)) begin
                n_val = 32'h7FFF_FFFF;
            end else begin
                n_val = n_q1[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

[rtl/small_matrix_det_inverse_top.sv]
`timescale 1ns / 1ps
// determinant and inverse of a 2x2 or 3x3 Q16.16 matrix, fully pipelined
// 6 arithmetic stages, 36 divider stages, 1 output register
// throughput one matrix per cycle; the whole pipe holds while the output waits
// the divider depth is set by the 34 quotient bits each of nine lanes resolves
// synchronous active-low reset clears the valid bits only
// depends on smdi_pkg, smdi_in_if, smdi_out_if, smdi_div_lane
module small_matrix_det_inverse_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smdi_in_if.sink    i_in,
    smdi_out_if.source o_res
);

    localparam int NE = smdi_pkg::N_ELEM;
    localparam int LAT = smdi_pkg::DIV_LAT;

    logic w_en;
    logic signed [smdi_pkg::ELEM_W-1:0] w_e [NE];

    logic                               r1_valid, r2_valid, r3_valid, r4_valid;
    logic                               r5_valid, r6_valid;
    logic                               r1_big, r2_big, r3_big, r4_big, r5_big, r6_big;
    logic signed [smdi_pkg::ELEM_W-1:0] r1_e [NE];
    logic signed [smdi_pkg::ELEM_W-1:0] r2_e [NE];
    logic signed [smdi_pkg::ELEM_W-1:0] r3_e [NE];
    logic signed [smdi_pkg::ELEM_W-1:0] r4_e [NE];
    logic signed [smdi_pkg::PROD_W-1:0] r1_pa [NE];
    logic signed [smdi_pkg::PROD_W-1:0] r1_pb [NE];
    logic signed [smdi_pkg::COF_W-1:0]  r2_cof [NE];
    logic signed [smdi_pkg::COF_W-1:0]  r3_cof [NE];
    logic signed [smdi_pkg::COF_W-1:0]  r4_cof [NE];
    logic signed [smdi_pkg::PART_W-1:0] r3_ph [3];
    logic signed [smdi_pkg::PART_W-1:0] r3_pl [3];
    logic signed [smdi_pkg::DET_W-1:0]  r4_term [3];
    logic signed [smdi_pkg::DET_W-1:0]  r5_det;
    logic signed [smdi_pkg::COF_W-1:0]  r5_adj [NE];
    logic [NE-1:0]                      r5_used, r6_used;
    logic [smdi_pkg::DMAG_W-1:0]        r6_det_mag;
    logic                               r6_det_neg;
    logic                               r6_zero;
    logic [smdi_pkg::NUM_W-1:0]         r6_num [NE];
    logic [NE-1:0]                      r6_neg;

    smdi_pkg::t_side                    r_side [LAT];
    logic [LAT-1:0]                     r_side_valid;
    smdi_pkg::t_side                    n_side;
    logic [smdi_pkg::DETQ_W-1:0]        n_detq_mag;

    logic [smdi_pkg::ELEM_W-1:0]        w_lane [NE];
    logic [smdi_pkg::ELEM_W-1:0]        w_inv [NE];
    smdi_pkg::t_out_data                r_out;
    logic                               r_out_valid;

    assign w_en       = !r_out_valid || o_res.ready;
    assign i_in.ready = w_en;

    assign w_e[0] = i_in.data.a_r0c0;
    assign w_e[1] = i_in.data.a_r0c1;
    assign w_e[2] = i_in.data.a_r0c2;
    assign w_e[3] = i_in.data.a_r1c0;
    assign w_e[4] = i_in.data.a_r1c1;
    assign w_e[5] = i_in.data.a_r1c2;
    assign w_e[6] = i_in.data.a_r2c0;
    assign w_e[7] = i_in.data.a_r2c1;
    assign w_e[8] = i_in.data.a_r2c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid     <= 1'b0;
            r2_valid     <= 1'b0;
            r3_valid     <= 1'b0;
            r4_valid     <= 1'b0;
            r5_valid     <= 1'b0;
            r6_valid     <= 1'b0;
            r_side_valid <= '0;
            r_out_valid  <= 1'b0;
        end else if (w_en) begin
            r1_valid     <= i_in.valid;
            r2_valid     <= r1_valid;
            r3_valid     <= r2_valid;
            r4_valid     <= r3_valid;
            r5_valid     <= r4_valid;
            r6_valid     <= r5_valid;
            r_side_valid <= {r_side_valid[LAT-2:0], r6_valid};
            r_out_valid  <= r_side_valid[LAT-1];
        end
    end

    // stages 1 and 2: element products and signed cofactors
    genvar gi, gj;
    generate
        for (gi = 0; gi < 3; gi++) begin : g_row
            for (gj = 0; gj < 3; gj++) begin : g_col
                localparam int K  = gi * 3 + gj;
                localparam int R0 = (gi == 0) ? 1 : 0;
                localparam int R1 = (gi == 2) ? 1 : 2;
                localparam int C0 = (gj == 0) ? 1 : 0;
                localparam int C1 = (gj == 2) ? 1 : 2;
                logic signed [smdi_pkg::COF_W-1:0] w_minor;
                assign w_minor = smdi_pkg::COF_W'(r1_pa[K]) - smdi_pkg::COF_W'(r1_pb[K]);
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r1_pa[K] <= smdi_pkg::PROD_W'(w_e[R0*3+C0])
                                  * smdi_pkg::PROD_W'(w_e[R1*3+C1]);
                        r1_pb[K] <= smdi_pkg::PROD_W'(w_e[R0*3+C1])
                                  * smdi_pkg::PROD_W'(w_e[R1*3+C0]);
                        r2_cof[K] <= (((gi + gj) % 2) == 1) ? -w_minor : w_minor;
                    end
                end
            end
        end
    endgenerate

    // stages 3 and 4: row-0 expansion, cofactor cut at bit 32 into a signed high and an unsigned low part
    generate
        for (gj = 0; gj < 3; gj++) begin : g_det
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r3_ph[gj] <= smdi_pkg::PART_W'(r2_e[gj])
                               * smdi_pkg::PART_W'($signed(r2_cof[gj][smdi_pkg::COF_W-1:32]));
                    r3_pl[gj] <= smdi_pkg::PART_W'(r2_e[gj])
                               * smdi_pkg::PART_W'($signed({1'b0, r2_cof[gj][31:0]}));
                    r4_term[gj] <= (smdi_pkg::DET_W'(r3_ph[gj]) <<< 32)
                                 + smdi_pkg::DET_W'(r3_pl[gj]);
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_big <= i_in.data.matrix_size == smdi_pkg::SIZE_3X3;
            r2_big <= r1_big;
            r3_big <= r2_big;
            r4_big <= r3_big;
            r5_big <= r4_big;
            r6_big <= r5_big;
            r1_e   <= w_e;
            r2_e   <= r1_e;
            r3_e   <= r2_e;
            r4_e   <= r3_e;
            r3_cof <= r2_cof;
            r4_cof <= r3_cof;
        end
    end

    // stage 5: determinant (3x3 row-0 sum, 2x2 minor of element 8) and adjugate per output element
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r4_big) begin
                r5_det <= r4_term[0] + r4_term[1] + r4_term[2];
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        r5_adj[i*3+j] <= r4_cof[j*3+i];
                    end
                end
                r5_used <= '1;
            end else begin
                r5_det    <= smdi_pkg::DET_W'(r4_cof[8]);
                r5_adj[0] <= smdi_pkg::COF_W'(r4_e[4]);
                r5_adj[1] <= -smdi_pkg::COF_W'(r4_e[1]);
                r5_adj[2] <= '0;
                r5_adj[3] <= -smdi_pkg::COF_W'(r4_e[3]);
                r5_adj[4] <= smdi_pkg::COF_W'(r4_e[0]);
                r5_adj[5] <= '0;
                r5_adj[6] <= '0;
                r5_adj[7] <= '0;
                r5_adj[8] <= '0;
                r5_used   <= NE'(9'b000011011);
            end
        end
    end

    // stage 6: magnitudes, signs and scaled numerators
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_det_neg <= r5_det[smdi_pkg::DET_W-1];
            r6_det_mag <= smdi_pkg::DMAG_W'(r5_det[smdi_pkg::DET_W-1] ? -r5_det : r5_det);
            r6_zero    <= r5_det == '0;
            r6_used    <= r5_used;
            for (int k = 0; k < NE; k++) begin
                r6_num[k] <= smdi_pkg::NUM_W'(smdi_pkg::PROD_W'(
                                 r5_adj[k][smdi_pkg::COF_W-1] ? -r5_adj[k] : r5_adj[k]))
                             << (2 * smdi_pkg::FRAC_BITS);
                r6_neg[k] <= r5_adj[k][smdi_pkg::COF_W-1] ^ r5_det[smdi_pkg::DET_W-1];
            end
        end
    end

    // determinant output: 3x3 drops FRAC_BITS with rounding, then 64-bit saturation
    always_comb begin
        if (r6_big) begin
            n_detq_mag = (smdi_pkg::DETQ_W'(r6_det_mag)
                          + smdi_pkg::DETQ_W'(1 << (smdi_pkg::FRAC_BITS - 1)))
                         >> smdi_pkg::FRAC_BITS;
        end else begin
            n_detq_mag = smdi_pkg::DETQ_W'(r6_det_mag);
        end
        n_side.zero = r6_zero;
        n_side.used = r6_used;
        if (r6_det_neg) begin
            if (n_detq_mag > smdi_pkg::DETQ_W'(64'h8000_0000_0000_0000)) begin
                n_side.det_q = 64'h8000_0000_0000_0000;
            end else begin
                n_side.det_q = 64'd0 - n_detq_mag[63:0];
            end
        end else begin
            if (n_detq_mag > smdi_pkg::DETQ_W'(64'h7FFF_FFFF_FFFF_FFFF)) begin
                n_side.det_q = 64'h7FFF_FFFF_FFFF_FFFF;
            end else begin
                n_side.det_q = n_detq_mag[63:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    generate
        for (gi = 0; gi < NE; gi++) begin : g_lane
            smdi_div_lane u_lane (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_num (r6_num[gi]),
                .i_den (r6_det_mag),
                .i_neg (r6_neg[gi]),
                .o_val (w_lane[gi])
            );
            assign w_inv[gi] = (r_side[LAT-1].zero || !r_side[LAT-1].used[gi])
                               ? '0 : w_lane[gi];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.status    <= r_side[LAT-1].zero;
            r_out.det_value <= r_side[LAT-1].zero ? '0 : r_side[LAT-1].det_q;
            r_out.inv_r0c0  <= w_inv[0];
            r_out.inv_r0c1  <= w_inv[1];
            r_out.inv_r0c2  <= w_inv[2];
            r_out.inv_r1c0  <= w_inv[3];
            r_out.inv_r1c1  <= w_inv[4];
            r_out.inv_r1c2  <= w_inv[5];
            r_out.inv_r2c0  <= w_inv[6];
            r_out.inv_r2c1  <= w_inv[7];
            r_out.inv_r2c2  <= w_inv[8];
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule
